// ----- hdl/kab_pkg.sv -----
package kab_pkg;

   localparam int NODE_FW    = 10;
   localparam int DIST_W     = 11;
   localparam int DEF_NODES  = 1024;
   localparam int DEF_LEVELS = 11;

   typedef struct packed {
      logic capture;
      logic clr_step;
      logic load_write;
      logic rb_start;
      logic rb_rd_self;
      logic rb_rd_mid;
      logic rb_write;
      logic q_start;
      logic q_read;
      logic q_take;
      logic q_skip;
      logic respond;
   } dp_cmd_type;

   typedef struct packed {
      logic is_load;
      logic node_ok;
      logic q_bad;
      logic clr_last;
      logic rb_last;
      logic bit_set;
      logic rest_zero;
      logic rd_valid;
   } dp_stat_type;

endpackage

// ----- hdl/kab_datapath.sv -----
module kab_datapath
   import kab_pkg::*;
#(
   parameter int NODES  = DEF_NODES,
   parameter int LEVELS = DEF_LEVELS
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   input  logic                req_action,
   input  logic [NODE_FW-1:0]  req_node,
   input  logic [NODE_FW-1:0]  req_parent,
   input  logic                req_has_parent,
   input  logic [DIST_W-1:0]   req_distance,
   output logic                rsp_strobe,
   output logic [NODE_FW-1:0]  rsp_ancestor,
   output logic                rsp_found
);

   localparam int NODE_W = $clog2(NODES);
   localparam int LVL_W  = $clog2(LEVELS);
   localparam int ENT_W  = NODE_W + 1;
   localparam int CMP_W  = (NODE_W + 1 > NODE_FW) ? NODE_W + 1 : NODE_FW;

   // entry: {valid, index}
   logic [ENT_W-1:0]   mem [LEVELS][NODES];

   logic               action_ff;
   logic [NODE_FW-1:0] node_ff;
   logic [NODE_FW-1:0] parent_ff;
   logic               has_par_ff;
   logic [DIST_W-1:0]  dist_ff;
   logic [NODE_W-1:0]  idx_ff;
   logic [LVL_W-1:0]   lvl_ff;
   logic [LVL_W-1:0]   bit_ff;
   logic [NODE_W-1:0]  cur_ff;
   logic               ok_ff;
   logic               e_valid_ff;
   logic [ENT_W-1:0]   rdata_ff;
   logic               strobe_ff;
   logic [NODE_FW-1:0] anc_ff;
   logic               found_ff;

   logic               wr_en;
   logic [LVL_W-1:0]   wr_lvl;
   logic [NODE_W-1:0]  wr_idx;
   logic [ENT_W-1:0]   wr_data;
   logic               rd_en;
   logic [LVL_W-1:0]   rd_lvl;
   logic [NODE_W-1:0]  rd_idx;
   logic [LVL_W-1:0]   lvl_m1;
   logic               idx_last;
   logic               par_ok;
   logic               hi_dist;

   assign lvl_m1   = lvl_ff - LVL_W'(1);
   assign idx_last = (idx_ff == NODE_W'(NODES - 1));
   assign par_ok   = has_par_ff && (CMP_W'(parent_ff) < CMP_W'(NODES));

   always_comb begin
      hi_dist = 1'b0;
      for (int b = 0; b < DIST_W; b++) begin
         if (b >= LEVELS && dist_ff[b]) begin
            hi_dist = 1'b1;
         end
      end
   end

   always_comb begin
      stat.is_load   = !action_ff;
      stat.node_ok   = (CMP_W'(node_ff) < CMP_W'(NODES));
      stat.q_bad     = !stat.node_ok || hi_dist;
      stat.clr_last  = idx_last;
      stat.rb_last   = idx_last && (lvl_ff == LVL_W'(LEVELS - 1));
      stat.bit_set   = dist_ff[0];
      stat.rest_zero = (dist_ff[DIST_W-1:1] == '0);
      stat.rd_valid  = rdata_ff[ENT_W-1];
   end

   always_comb begin
      wr_en   = cmd.clr_step || cmd.load_write || cmd.rb_write;
      wr_lvl  = '0;
      wr_idx  = idx_ff;
      wr_data = '0;
      if (cmd.load_write) begin
         wr_idx  = NODE_W'(node_ff);
         wr_data = par_ok ? {1'b1, NODE_W'(parent_ff)} : '0;
      end else if (cmd.rb_write) begin
         wr_lvl  = lvl_ff;
         wr_data = e_valid_ff ? rdata_ff : '0;
      end
   end

   always_comb begin
      rd_en  = cmd.rb_rd_self || cmd.rb_rd_mid || cmd.q_read;
      rd_lvl = lvl_m1;
      rd_idx = idx_ff;
      if (cmd.rb_rd_mid) begin
         rd_idx = rdata_ff[NODE_W-1:0];
      end else if (cmd.q_read) begin
         rd_lvl = bit_ff;
         rd_idx = cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_lvl][wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_lvl][rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff  <= req_action;
         node_ff    <= req_node;
         parent_ff  <= req_parent;
         has_par_ff <= req_has_parent;
      end
      if (cmd.rb_rd_mid) begin
         e_valid_ff <= rdata_ff[ENT_W-1];
      end
      if (cmd.q_start) begin
         cur_ff <= NODE_W'(node_ff);
      end else if (cmd.q_take && rdata_ff[ENT_W-1]) begin
         cur_ff <= rdata_ff[NODE_W-1:0];
      end
      if (cmd.respond) begin
         anc_ff   <= ok_ff ? NODE_FW'(cur_ff) : '0;
         found_ff <= ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         lvl_ff    <= '0;
         bit_ff    <= '0;
         ok_ff     <= 1'b0;
         dist_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.respond;
         if (cmd.capture) begin
            dist_ff <= req_distance;
         end else if (cmd.q_skip || cmd.q_take) begin
            dist_ff <= dist_ff >> 1;
         end
         if (cmd.rb_start) begin
            idx_ff <= '0;
            lvl_ff <= LVL_W'(1);
         end else if (cmd.clr_step) begin
            idx_ff <= idx_last ? '0 : idx_ff + NODE_W'(1);
         end else if (cmd.rb_write) begin
            idx_ff <= idx_last ? '0 : idx_ff + NODE_W'(1);
            if (idx_last) begin
               lvl_ff <= lvl_ff + LVL_W'(1);
            end
         end
         if (cmd.q_start) begin
            bit_ff <= '0;
            ok_ff  <= !stat.q_bad;
         end else if (cmd.q_skip || cmd.q_take) begin
            bit_ff <= bit_ff + LVL_W'(1);
            if (cmd.q_take && !rdata_ff[ENT_W-1]) begin
               ok_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_ancestor = anc_ff;
   assign rsp_found    = found_ff;

endmodule

// ----- hdl/kab_ctrl.sv -----
module kab_ctrl
   import kab_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_RB_SELF,
      ST_RB_MID,
      ST_RB_WRITE,
      ST_Q_START,
      ST_Q_STEP,
      ST_Q_WAIT,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      stale_ff;

   // level 0 is cleared after reset; stale forces the upper levels to follow
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         stale_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               if (stat.clr_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (start) state_ff <= ST_DECODE;
            end
            ST_DECODE: begin
               if (stat.is_load) begin
                  if (stat.node_ok) stale_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else if (stale_ff) begin
                  state_ff <= ST_RB_SELF;
               end else begin
                  state_ff <= ST_Q_START;
               end
            end
            ST_RB_SELF:  state_ff <= ST_RB_MID;
            ST_RB_MID:   state_ff <= ST_RB_WRITE;
            ST_RB_WRITE: begin
               if (stat.rb_last) begin
                  stale_ff <= 1'b0;
                  state_ff <= ST_Q_START;
               end else begin
                  state_ff <= ST_RB_SELF;
               end
            end
            ST_Q_START: state_ff <= stat.q_bad ? ST_RESP : ST_Q_STEP;
            ST_Q_STEP: begin
               if (stat.bit_set) state_ff <= ST_Q_WAIT;
               else if (stat.rest_zero) state_ff <= ST_RESP;
            end
            ST_Q_WAIT: begin
               if (!stat.rd_valid || stat.rest_zero) state_ff <= ST_RESP;
               else state_ff <= ST_Q_STEP;
            end
            ST_RESP: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.capture    = (state_ff == ST_IDLE) && start;
      cmd.clr_step   = (state_ff == ST_CLEAR);
      cmd.load_write = (state_ff == ST_DECODE) && stat.is_load && stat.node_ok;
      cmd.rb_start   = (state_ff == ST_DECODE) && !stat.is_load && stale_ff;
      cmd.rb_rd_self = (state_ff == ST_RB_SELF);
      cmd.rb_rd_mid  = (state_ff == ST_RB_MID);
      cmd.rb_write   = (state_ff == ST_RB_WRITE);
      cmd.q_start    = (state_ff == ST_Q_START);
      cmd.q_read     = (state_ff == ST_Q_STEP) && stat.bit_set;
      cmd.q_skip     = (state_ff == ST_Q_STEP) && !stat.bit_set && !stat.rest_zero;
      cmd.q_take     = (state_ff == ST_Q_WAIT);
      cmd.respond    = (state_ff == ST_RESP);
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- hdl/kth_ancestor_binary_lifting.sv -----
// Load word: busy while the word is decoded and written, no result.
// Query word: the walk steps through the bits of distance up to the highest set
// bit, reading the table at each set bit; a serial table rebuild comes first when a
// load of an in-range node came before; one jump-table port sets this.
// Reset: synchronous; busy while level 0 of the table is cleared.
// Results are shown for one cycle on rsp_strobe; the receiver cannot stall.
module kth_ancestor_binary_lifting
   import kab_pkg::*;
#(
   parameter int NODES  = DEF_NODES,
   parameter int LEVELS = DEF_LEVELS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  logic [NODE_FW-1:0]  req_node,
   input  logic [NODE_FW-1:0]  req_parent,
   input  logic                req_has_parent,
   input  logic [DIST_W-1:0]   req_distance,
   output logic                rsp_strobe,
   output logic [NODE_FW-1:0]  rsp_ancestor,
   output logic                rsp_found
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   kab_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   kab_datapath #(
      .NODES  (NODES),
      .LEVELS (LEVELS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_action),
      .req_node       (req_node),
      .req_parent     (req_parent),
      .req_has_parent (req_has_parent),
      .req_distance   (req_distance),
      .rsp_strobe     (rsp_strobe),
      .rsp_ancestor   (rsp_ancestor),
      .rsp_found      (rsp_found)
   );

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held two cycles");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_found |-> rsp_ancestor == '0)
      else $error("not-found result with nonzero ancestor");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_one_cmd_write: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.clr_step, cmd.load_write, cmd.rb_write}) <= 1)
      else $error("table write conflict");

endmodule

// ----- verif/tb_kth_ancestor_binary_lifting.sv -----
`timescale 1ns / 100ps

module tb_kth_ancestor_binary_lifting
   import kab_pkg::*;
();

   localparam int N_NODES    = DEF_NODES;
   localparam int N_LEVELS   = DEF_LEVELS;
   localparam int QUIET_MAX  = 150000;
   localparam int CALM_WORDS = 200;
   localparam int N_PHASES   = 16;

   typedef enum logic {
      WORD_LOAD  = 1'b0,
      WORD_QUERY = 1'b1
   } word_kind_type;

   typedef struct {
      word_kind_type        action;
      logic [NODE_FW-1:0]   node;
      logic [NODE_FW-1:0]   parent;
      logic                 has_parent;
      logic [DIST_W-1:0]    distance;
   } tree_word_type;

   typedef struct {
      logic [NODE_FW-1:0] ancestor;
      logic               found;
   } answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_action = 1'b0;
   logic [NODE_FW-1:0]  req_node = '0;
   logic [NODE_FW-1:0]  req_parent = '0;
   logic                req_has_parent = 1'b0;
   logic [DIST_W-1:0]   req_distance = '0;
   logic                rsp_strobe;
   logic [NODE_FW-1:0]  rsp_ancestor;
   logic                rsp_found;

   tree_word_type       pending_words[$];
   answer_type          expected_answers[$];
   logic [NODE_FW-1:0]  loaded_nodes[$];

   logic                jump_ok  [N_LEVELS][N_NODES];
   logic [NODE_FW-1:0]  jump_idx [N_LEVELS][N_NODES];
   logic                levels_stale;

   tree_word_type       shown;
   logic                slot_full = 1'b0;
   int                  idle_left = 0;
   logic                bursts_on = 1'b1;
   int                  quiet_cycles = 0;
   int                  errors = 0;

   kth_ancestor_binary_lifting uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_node       (req_node),
      .req_parent     (req_parent),
      .req_has_parent (req_has_parent),
      .req_distance   (req_distance),
      .rsp_strobe     (rsp_strobe),
      .rsp_ancestor   (rsp_ancestor),
      .rsp_found      (rsp_found)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic void rebuild_jumps();
      logic [NODE_FW-1:0] mid;
      for (int lv = 1; lv < N_LEVELS; lv++) begin
         for (int i = 0; i < N_NODES; i++) begin
            if (jump_ok[lv-1][i]) begin
               mid = jump_idx[lv-1][i];
               jump_ok[lv][i]  = jump_ok[lv-1][mid];
               jump_idx[lv][i] = jump_idx[lv-1][mid];
            end else begin
               jump_ok[lv][i]  = 1'b0;
               jump_idx[lv][i] = '0;
            end
         end
      end
      levels_stale = 1'b0;
   endfunction

   function automatic void apply_to_forest(tree_word_type w);
      logic [NODE_FW-1:0] cur;
      logic               ok;
      answer_type         ans;
      if (w.action == WORD_LOAD) begin
         jump_ok[0][w.node]  = w.has_parent;
         jump_idx[0][w.node] = w.has_parent ? w.parent : '0;
         levels_stale = 1'b1;
         return;
      end
      if (levels_stale)
         rebuild_jumps();
      cur = w.node;
      ok  = 1'b1;
      for (int b = 0; b < DIST_W; b++) begin
         if (ok && w.distance[b]) begin
            if (b >= N_LEVELS || !jump_ok[b][cur])
               ok = 1'b0;
            else
               cur = jump_idx[b][cur];
         end
      end
      ans.ancestor = ok ? cur : '0;
      ans.found    = ok;
      expected_answers.push_back(ans);
   endfunction

   task automatic push_load(input logic [NODE_FW-1:0] n, input logic [NODE_FW-1:0] p,
                            input logic hp);
      tree_word_type w;
      w.action     = WORD_LOAD;
      w.node       = n;
      w.parent     = p;
      w.has_parent = hp;
      w.distance   = DIST_W'($urandom);
      pending_words.push_back(w);
      loaded_nodes.push_back(n);
      if (loaded_nodes.size() > 256)
         void'(loaded_nodes.pop_front());
   endtask

   task automatic push_query(input logic [NODE_FW-1:0] n, input logic [DIST_W-1:0] d);
      tree_word_type w;
      w.action     = WORD_QUERY;
      w.node       = n;
      w.parent     = NODE_FW'($urandom);
      w.has_parent = 1'($urandom);
      w.distance   = d;
      pending_words.push_back(w);
   endtask

   // accept and predict
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         apply_to_forest(shown);
         slot_full = 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!slot_full) begin
         if ($urandom_range(0, 199) == 0)
            bursts_on = !bursts_on;
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (pending_words.size() > CALM_WORDS && bursts_on &&
                      $urandom_range(0, 5) == 0) begin
            idle_left = $urandom_range(1, 11) - 1;
            start <= 1'b0;
         end else if (pending_words.size() > 0) begin
            shown = pending_words.pop_front();
            slot_full = 1'b1;
            req_action     <= shown.action;
            req_node       <= shown.node;
            req_parent     <= shown.parent;
            req_has_parent <= shown.has_parent;
            req_distance   <= shown.distance;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_strobe) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected word: expected none, actual ancestor %0d found %0d",
                     $time, rsp_ancestor, rsp_found);
            errors++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_ancestor !== want.ancestor) begin
               $display("%0t: ancestor mismatch: expected %0d, actual %0d",
                        $time, want.ancestor, rsp_ancestor);
               errors++;
            end
            if (rsp_found !== want.found) begin
               $display("%0t: found mismatch: expected %0d, actual %0d",
                        $time, want.found, rsp_found);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [NODE_FW-1:0] base;
      logic [NODE_FW-1:0] link;
      logic [NODE_FW-1:0] qn;
      logic [DIST_W-1:0]  qd;
      int                 len;
      int                 n_loads;
      int                 n_queries;
      int                 pick;

      for (int lv = 0; lv < N_LEVELS; lv++) begin
         for (int i = 0; i < N_NODES; i++) begin
            jump_ok[lv][i]  = 1'b0;
            jump_idx[lv][i] = '0;
         end
      end
      levels_stale = 1'b0;

      // empty forest: every node is a root
      push_query(10'd0, 11'd0);
      push_query(10'd1023, 11'd1);
      push_query(10'd5, 11'd2047);
      // two-node cycle, self loop, short chain, root with parent bits set
      push_load(10'd1023, 10'd0, 1'b1);
      push_load(10'd0, 10'd1023, 1'b1);
      push_load(10'd512, 10'd512, 1'b1);
      push_load(10'd1, 10'd0, 1'b1);
      push_load(10'd2, 10'd1, 1'b1);
      push_load(10'd3, 10'd1023, 1'b0);
      push_query(10'd2, 11'd1);
      push_query(10'd2, 11'd2047);
      push_query(10'd512, 11'd2047);
      push_query(10'd3, 11'd1);
      push_query(10'd1023, 11'd1024);
      push_query(10'd0, 11'd0);
      push_query(10'd3, 11'd0);
      push_load(10'd512, 10'd0, 1'b0);
      push_query(10'd512, 11'd1);
      push_query(10'd1, 11'd3);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         n_loads = $urandom_range(35, 55);
         while (n_loads > 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               base = NODE_FW'($urandom);
               len  = $urandom_range(2, 16);
               if (loaded_nodes.size() > 0 && $urandom_range(0, 3) != 0)
                  link = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
               else
                  link = NODE_FW'($urandom);
               push_load(base, link, $urandom_range(0, 4) != 0);
               for (int j = 1; j < len; j++)
                  push_load(base + NODE_FW'(j), base + NODE_FW'(j - 1), 1'b1);
               n_loads -= len;
            end else if (pick == 7) begin
               base = NODE_FW'($urandom);
               push_load(base, base, 1'b1);
               n_loads--;
            end else if (pick == 8) begin
               push_load(NODE_FW'($urandom), NODE_FW'($urandom), 1'b0);
               n_loads--;
            end else begin
               push_load(NODE_FW'($urandom), NODE_FW'($urandom), 1'b1);
               n_loads--;
            end
         end
         n_queries = $urandom_range(60, 85);
         for (int q = 0; q < n_queries; q++) begin
            if (loaded_nodes.size() > 0 && $urandom_range(0, 2) != 0)
               qn = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
            else
               qn = NODE_FW'($urandom);
            pick = $urandom_range(0, 19);
            if (pick < 9)
               qd = DIST_W'($urandom_range(0, 31));
            else if (pick < 12)
               qd = DIST_W'(1) << $urandom_range(0, DIST_W - 1);
            else if (pick < 13)
               qd = '0;
            else if (pick < 15)
               qd = DIST_W'($urandom_range(32, 300));
            else
               qd = DIST_W'($urandom);
            push_query(qn, qd);
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || slot_full || expected_answers.size() != 0)
         @(posedge clock);
      repeat (64) @(posedge clock);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
